// ----- hdl/text_console_cursor_scroll_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the text console block.
// Clocked, reset-qualified property checks that report through $error.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TCC_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the clock cycle after its antecedent.
`define TCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tcc_pkg.sv -----
// ---------------------------------------------------------------------------
// Text console package
// Shared types, codes and default dimensions of the text console block.
// ---------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    localparam int DEF_COLS     = 80;
    localparam int DEF_ROWS     = 25;

    localparam int CELL_W       = 16;
    localparam int CODE_W       = 8;
    localparam int COLOR_W      = 8;
    localparam int NIBBLE_W     = 4;
    localparam int FUNC_W       = 2;
    localparam int COL_FIELD_W  = 7;
    localparam int ROW_FIELD_W  = 5;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CODE_W-1:0]   NEWLINE_CODE = 8'd10;
    localparam logic [NIBBLE_W-1:0] FORE_RESET   = 4'hF;
    localparam logic [NIBBLE_W-1:0] BACK_RESET   = 4'h0;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT   = 2'd0,
        FN_CLEAR = 2'd1,
        FN_READ  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORE = 1'b0,
        CFG_BACK = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_BLANK,
        ST_PUT,
        ST_DONE
    } t_tcc_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ----- hdl/tcc_if.sv -----
// ---------------------------------------------------------------------------
// Text console channels
// Command, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

interface tcc_cmd_if import tcc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [CODE_W-1:0]      char_code;
    logic [COL_FIELD_W-1:0] cell_col;
    logic [ROW_FIELD_W-1:0] cell_row;

    modport source (output valid, func, char_code, cell_col, cell_row, input ready);
    modport sink   (input valid, func, char_code, cell_col, cell_row, output ready);
endinterface

interface tcc_res_if import tcc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic [ROW_FIELD_W-1:0] cursor_line;
    logic [CODE_W-1:0]      read_code;
    logic [COLOR_W-1:0]     read_color;

    modport source (output valid, cursor_column, cursor_line, read_code, read_color,
                    input ready);
    modport sink   (input valid, cursor_column, cursor_line, read_code, read_color,
                    output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [NIBBLE_W-1:0]  data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/tcc_mem.sv -----
// ---------------------------------------------------------------------------
// Text console cell memory
// Screen store with one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_mem import tcc_pkg::*; #(
    parameter int DEPTH = DEF_COLS * DEF_ROWS,
    parameter int AW    = $clog2(DEF_COLS * DEF_ROWS)
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [CELL_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [CELL_W-1:0] o_rd_data
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hdl/tcc_ctrl.sv -----
// ---------------------------------------------------------------------------
// Text console controller
// Cursor state, command sequencing, scroll and blank sweeps, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_ctrl import tcc_pkg::*; #(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS,
    parameter int AW   = $clog2(DEF_COLS * DEF_ROWS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tcc_cmd_if.sink            i_cmd,
    tcc_res_if.source          o_res,
    input  logic [COLOR_W-1:0] i_color,
    output t_mem_ctl           o_mem_ctl,
    output logic [AW-1:0]      o_wr_addr,
    output logic [CELL_W-1:0]  o_wr_data,
    output logic [AW-1:0]      o_rd_addr,
    input  logic [CELL_W-1:0]  i_rd_data
);

    localparam int TOTAL    = ROWS * COLS;
    localparam int SCROLL_N = (ROWS - 1) * COLS;
    localparam int CW       = $clog2(COLS + 1);
    localparam int RW       = $clog2(ROWS);
    localparam int NW       = $clog2(TOTAL + 1);

    t_tcc_state              r_state, n_state;
    logic [CW-1:0]           r_col, n_col;
    logic [RW-1:0]           r_row, n_row;
    logic [AW-1:0]           r_base, n_base;
    logic [NW-1:0]           r_cnt, n_cnt;
    logic                    r_pend, n_pend;
    logic [CODE_W-1:0]       r_pend_code, n_pend_code;
    logic                    r_rd_hit, n_rd_hit;
    logic                    r_out_valid, n_out_valid;
    logic [COL_FIELD_W-1:0]  r_out_col, n_out_col;
    logic [ROW_FIELD_W-1:0]  r_out_row, n_out_row;
    logic [CODE_W-1:0]       r_out_code, n_out_code;
    logic [COLOR_W-1:0]      r_out_color, n_out_color;

    logic                    is_newline;
    logic                    is_wrap;
    logic                    is_last_row;
    logic                    rd_in_range;
    logic                    out_free;
    logic                    init_end;
    logic                    scroll_end;
    logic                    blank_end;
    logic [AW-1:0]           rd_cell_addr;

    assign is_newline   = i_cmd.char_code == NEWLINE_CODE;
    assign is_wrap      = r_col == CW'(COLS);
    assign is_last_row  = r_row == RW'(ROWS - 1);
    assign rd_in_range  = ({1'b0, i_cmd.cell_col} < 8'(COLS))
                       && ({2'b00, i_cmd.cell_row} < 7'(ROWS));
    assign rd_cell_addr = AW'(AW'(i_cmd.cell_row) * AW'(COLS)) + AW'(i_cmd.cell_col);
    assign out_free     = !r_out_valid || o_res.ready;
    assign init_end     = r_cnt == NW'(TOTAL - 1);
    assign scroll_end   = r_cnt == NW'(SCROLL_N);
    assign blank_end    = r_cnt == NW'(TOTAL - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (init_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (t_func'(i_cmd.func))
                        FN_PUT: begin
                            if (is_last_row && (is_newline || is_wrap)) begin
                                n_state = ST_SCROLL;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        FN_CLEAR: n_state = ST_BLANK;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCROLL: begin
                if (scroll_end) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (blank_end) begin
                    n_state = r_pend ? ST_PUT : ST_DONE;
                end
            end
            ST_PUT: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_code = r_pend_code;
        n_rd_hit    = r_rd_hit;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_code  = r_out_code;
        n_out_color = r_out_color;
        o_mem_ctl   = '0;
        o_wr_addr   = '0;
        o_wr_data   = '0;
        o_rd_addr   = '0;

        unique case (r_state)
            ST_INIT: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_cnt[AW-1:0];
                n_cnt           = r_cnt + NW'(1);
            end
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_rd_hit = 1'b0;
                    unique case (t_func'(i_cmd.func))
                        FN_PUT: begin
                            if (is_newline) begin
                                n_col = '0;
                                if (is_last_row) begin
                                    n_cnt  = '0;
                                    n_pend = 1'b0;
                                end else begin
                                    n_row  = r_row + RW'(1);
                                    n_base = r_base + AW'(COLS);
                                end
                            end else if (is_wrap) begin
                                if (is_last_row) begin
                                    n_col       = '0;
                                    n_cnt       = '0;
                                    n_pend      = 1'b1;
                                    n_pend_code = i_cmd.char_code;
                                end else begin
                                    o_mem_ctl.wr_en = 1'b1;
                                    o_wr_addr       = r_base + AW'(COLS);
                                    o_wr_data       = {i_color, i_cmd.char_code};
                                    n_row           = r_row + RW'(1);
                                    n_base          = r_base + AW'(COLS);
                                    n_col           = CW'(1);
                                end
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                o_wr_addr       = r_base + AW'(r_col);
                                o_wr_data       = {i_color, i_cmd.char_code};
                                n_col           = r_col + CW'(1);
                            end
                        end
                        FN_CLEAR: begin
                            n_col  = '0;
                            n_row  = '0;
                            n_base = '0;
                            n_cnt  = '0;
                            n_pend = 1'b0;
                        end
                        FN_READ: begin
                            o_mem_ctl.rd_en = rd_in_range;
                            o_rd_addr       = rd_cell_addr;
                            n_rd_hit        = rd_in_range;
                        end
                        default: begin
                            n_rd_hit = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                o_mem_ctl.rd_en = !scroll_end;
                o_rd_addr       = r_cnt[AW-1:0] + AW'(COLS);
                o_mem_ctl.wr_en = r_cnt != '0;
                o_wr_addr       = r_cnt[AW-1:0] - AW'(1);
                o_wr_data       = i_rd_data;
                if (!scroll_end) begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            ST_BLANK: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_cnt[AW-1:0];
                o_wr_data       = {i_color, CODE_W'(0)};
                n_cnt           = r_cnt + NW'(1);
            end
            ST_PUT: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_base;
                o_wr_data       = {i_color, r_pend_code};
                n_col           = CW'(1);
                n_pend          = 1'b0;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_col   = COL_FIELD_W'(r_col);
                    n_out_row   = ROW_FIELD_W'(r_row);
                    n_out_code  = r_rd_hit ? i_rd_data[CODE_W-1:0] : '0;
                    n_out_color = r_rd_hit ? i_rd_data[CELL_W-1:CODE_W] : '0;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_base      <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_rd_hit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_base      <= n_base;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_rd_hit    <= n_rd_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_code <= n_pend_code;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
        r_out_code  <= n_out_code;
        r_out_color <= n_out_color;
    end

    assign i_cmd.ready         = r_state == ST_IDLE;
    assign o_res.valid         = r_out_valid;
    assign o_res.cursor_column = r_out_col;
    assign o_res.cursor_line   = r_out_row;
    assign o_res.read_code     = r_out_code;
    assign o_res.read_color    = r_out_color;

endmodule

`default_nettype wire

// ----- hdl/text_console_cursor_scroll.sv -----
// ---------------------------------------------------------------------------
// Text console with cursor, wrap and scroll
// Character-cell screen store with cursor tracking, line wrap and scrolling.
// ---------------------------------------------------------------------------
// Commands arrive on i_cmd (put character, clear screen, read cell) and each
// one returns exactly one result transfer on o_res with the cursor position
// after the command and, for a read, the code and color byte of the cell.
// The colors used for written and blanked cells are set over i_cfg, which
// is always ready; index 0 is the foreground nibble, index 1 the background.
// A put that stays on the screen and a read go from idle to the done step,
// with the memory access in the accepting cycle; the done step loads the
// result register once it is free, and idle then takes the next command.
// A newline or a wrapping put on the last row scrolls the store one cell
// per cycle, then blanks the last row and, for a wrapping put, writes the
// character at the start of that row; a clear blanks the whole store. All
// sweeps go through the single memory port pair.
// After reset the store is cleared to zero one cell per cycle, while
// i_cmd.ready stays low. Only one command is in flight at a
// time; a finished result waits in the output register while the next
// command is accepted, and a stalled receiver holds the block in its final
// step until the register is free.
// ---------------------------------------------------------------------------
`default_nettype none

`include "text_console_cursor_scroll_assert.svh"

module text_console_cursor_scroll import tcc_pkg::*; #(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcc_cmd_if.sink   i_cmd,
    tcc_res_if.source o_res,
    tcc_cfg_if.sink   i_cfg
);

    localparam int AW = $clog2(ROWS * COLS);

    logic [NIBBLE_W-1:0] r_fore;
    logic [NIBBLE_W-1:0] r_back;
    logic [COLOR_W-1:0]  color;
    t_mem_ctl            mem_ctl;
    logic [AW-1:0]       wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic [AW-1:0]       rd_addr;
    logic [CELL_W-1:0]   rd_data;

    assign i_cfg.ready = 1'b1;
    assign color       = {r_back, r_fore};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore <= FORE_RESET;
            r_back <= BACK_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.idx))
                CFG_FORE: r_fore <= i_cfg.data;
                CFG_BACK: r_back <= i_cfg.data;
                default:  r_fore <= r_fore;
            endcase
        end
    end

    tcc_ctrl #(
        .COLS (COLS),
        .ROWS (ROWS),
        .AW   (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_res     (o_res),
        .i_color   (color),
        .o_mem_ctl (mem_ctl),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    tcc_mem #(
        .DEPTH (ROWS * COLS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    `TCC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, !i_cmd.ready, "Command accepted while another is in flight.")
    `TCC_ASSERT_ALWAYS(a_col_bound, i_clk, i_rst_n, !o_res.valid || ({1'b0, o_res.cursor_column} <= 8'(COLS)), "Cursor column beyond the wrap position.")
    `TCC_ASSERT_ALWAYS(a_result_frees, i_clk, i_rst_n, !$rose(o_res.valid) || i_cmd.ready, "Result loaded without returning to idle.")

endmodule

`default_nettype wire

// ----- verif/tb_text_console_cursor_scroll.sv -----
// ---------------------------------------------------------------------------
// Text console cursor and scroll testbench
// Drives put, clear, read and unused commands plus color register writes
// into the console, predicts every result transfer from a local model of
// the screen store and cursor, and checks each result field by field under
// varying source idle and sink stall patterns.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_text_console_cursor_scroll;
    import tcc_pkg::*;

    localparam int COLS        = DEF_COLS;
    localparam int ROWS        = DEF_ROWS;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int MAX_REPORTS = 10;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] column;
        logic [ROW_FIELD_W-1:0] line;
        logic [CODE_W-1:0]      code;
        logic [COLOR_W-1:0]     color;
    } t_console_status;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcc_cmd_if cmd_bus ();
    tcc_res_if res_bus ();
    tcc_cfg_if cfg_bus ();

    text_console_cursor_scroll dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    logic [CELL_W-1:0]   screen_model [ROWS*COLS];
    int unsigned         model_col;
    int unsigned         model_row;
    logic [NIBBLE_W-1:0] model_fore;
    logic [NIBBLE_W-1:0] model_back;

    t_console_status     pending_status_q [$];
    t_console_status     got_status;
    t_console_status     want_status;

    int unsigned         cycle_count = 0;
    int unsigned         error_count = 0;
    int unsigned         src_idle_pct = 0;
    int unsigned         sink_stall_pct = 0;
    int unsigned         sink_hold_cycles = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_text_console_cursor_scroll: FAIL");
            $finish;
        end
    end

    // Screen model

    function automatic logic [COLOR_W-1:0] model_color();
        return {model_back, model_fore};
    endfunction

    function automatic void model_newline();
        int i;
        model_col = 0;
        if (model_row + 1 < ROWS) begin
            model_row++;
        end else begin
            model_row = ROWS - 1;
            for (i = 0; i < (ROWS - 1) * COLS; i++)
                screen_model[i] = screen_model[i + COLS];
            for (i = (ROWS - 1) * COLS; i < ROWS * COLS; i++)
                screen_model[i] = {model_color(), 8'h00};
        end
    endfunction

    function automatic t_console_status console_step(
        input logic [FUNC_W-1:0]      fn,
        input logic [CODE_W-1:0]      code,
        input logic [COL_FIELD_W-1:0] col,
        input logic [ROW_FIELD_W-1:0] row
    );
        t_console_status st;
        logic [CELL_W-1:0] cell_word;
        int i;
        st = '0;
        case (fn)
            FN_PUT: begin
                if (code == NEWLINE_CODE) begin
                    model_newline();
                end else begin
                    if (model_col >= COLS)
                        model_newline();
                    screen_model[model_row * COLS + model_col] = {model_color(), code};
                    model_col++;
                end
            end
            FN_CLEAR: begin
                model_col = 0;
                model_row = 0;
                for (i = 0; i < ROWS * COLS; i++)
                    screen_model[i] = {model_color(), 8'h00};
            end
            FN_READ: begin
                if (col < COLS && row < ROWS) begin
                    cell_word = screen_model[row * COLS + col];
                    st.code  = cell_word[CODE_W-1:0];
                    st.color = cell_word[CELL_W-1:CODE_W];
                end
            end
            default: begin
            end
        endcase
        st.column = model_col[COL_FIELD_W-1:0];
        st.line   = model_row[ROW_FIELD_W-1:0];
        return st;
    endfunction

    // Result checker and sink

    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            res_bus.ready <= 1'b0;
            sink_hold_cycles = sink_hold_cycles - 1;
        end else begin
            res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic report_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display({"%s: expected col=%0d row=%0d code=%02h color=%02h,",
                      " got col=%0d row=%0d code=%02h color=%02h"},
                     what, want_status.column, want_status.line, want_status.code,
                     want_status.color, got_status.column, got_status.line,
                     got_status.code, got_status.color);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got_status = {res_bus.cursor_column, res_bus.cursor_line,
                          res_bus.read_code, res_bus.read_color};
            if (pending_status_q.size() == 0) begin
                want_status = '0;
                report_error("Unexpected result transfer");
            end else begin
                want_status = pending_status_q.pop_front();
                if (got_status.column !== want_status.column
                    || got_status.line !== want_status.line
                    || got_status.code !== want_status.code
                    || got_status.color !== want_status.color)
                    report_error("Result mismatch");
            end
        end
    end

    // Command and register drivers

    task automatic send_command(
        input logic [FUNC_W-1:0]      fn,
        input logic [CODE_W-1:0]      code,
        input logic [COL_FIELD_W-1:0] col,
        input logic [ROW_FIELD_W-1:0] row
    );
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.func      <= fn;
        cmd_bus.char_code <= code;
        cmd_bus.cell_col  <= col;
        cmd_bus.cell_row  <= row;
        do @(posedge i_clk); while (!cmd_bus.ready);
        pending_status_q.push_back(console_step(fn, code, col, row));
    endtask

    task automatic put_char(input logic [CODE_W-1:0] code);
        send_command(FN_PUT, code, COL_FIELD_W'($urandom_range(127)),
                     ROW_FIELD_W'($urandom_range(31)));
    endtask

    task automatic read_cell(input logic [COL_FIELD_W-1:0] col,
                             input logic [ROW_FIELD_W-1:0] row);
        send_command(FN_READ, CODE_W'($urandom_range(255)), col, row);
    endtask

    task automatic clear_screen();
        send_command(FN_CLEAR, CODE_W'($urandom_range(255)),
                     COL_FIELD_W'($urandom_range(127)), ROW_FIELD_W'($urandom_range(31)));
    endtask

    task automatic wait_console_idle();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_color(input t_cfg_idx idx, input logic [NIBBLE_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.idx   <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == CFG_FORE)
            model_fore = value;
        else
            model_back = value;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_colors(input logic [NIBBLE_W-1:0] fore,
                              input logic [NIBBLE_W-1:0] back);
        wait_console_idle();
        write_color(CFG_FORE, fore);
        write_color(CFG_BACK, back);
    endtask

    // Tests

    task automatic test_basic_commands();
        read_cell(0, 0);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        send_command(FN_PUT, NEWLINE_CODE, 7'h7F, 5'h1F);
        read_cell(0, 0);
        read_cell(1, 0);
        read_cell(2, 0);
        read_cell(COLS - 1, ROWS - 1);
        read_cell(COLS, 0);
        read_cell(0, ROWS);
        read_cell(7'h7F, 5'h1F);
        send_command(FN_UNUSED, 8'hFF, 7'h7F, 5'h1F);
        send_command(FN_UNUSED, 8'h00, 7'h00, 5'h00);
        clear_screen();
        read_cell(0, 0);
        read_cell(COLS - 1, ROWS - 1);
    endtask

    task automatic test_color_registers();
        set_colors(4'h0, 4'hF);
        put_char(8'h5A);
        read_cell(0, 0);
        set_colors(4'h0, 4'h0);
        clear_screen();
        put_char(8'hA5);
        read_cell(0, 0);
        read_cell(5, 3);
        set_colors(4'hF, 4'hF);
        put_char(8'h33);
        read_cell(1, 0);
        set_colors(FORE_RESET, BACK_RESET);
    endtask

    task automatic test_wrap_and_scroll();
        int i;
        clear_screen();
        for (i = 0; i < ROWS - 1; i++)
            send_command(FN_PUT, NEWLINE_CODE, COL_FIELD_W'($urandom_range(127)),
                         ROW_FIELD_W'($urandom_range(31)));
        for (i = 0; i < COLS; i++)
            put_char(CODE_W'(8'h20 + (i % 90)));
        put_char(8'h7E);
        read_cell(0, ROWS - 2);
        read_cell(COLS - 1, ROWS - 2);
        read_cell(0, ROWS - 1);
        read_cell(1, ROWS - 1);
        for (i = 1; i < COLS; i++)
            put_char(CODE_W'($urandom_range(255) == NEWLINE_CODE ? 8'h2E
                                                                 : $urandom_range(255)));
        send_command(FN_PUT, NEWLINE_CODE, 7'h00, 5'h00);
        read_cell(COLS - 1, ROWS - 2);
        read_cell(0, ROWS - 1);
        read_cell(COLS - 1, ROWS - 3);
    endtask

    task automatic test_backpressure();
        int i;
        wait_console_idle();
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 400;
        for (i = 0; i < 30; i++) begin
            if (i % 3 == 2)
                read_cell(COL_FIELD_W'($urandom_range(COLS - 1)), ROW_FIELD_W'(model_row));
            else
                put_char(CODE_W'(8'h61 + i));
        end
        wait_console_idle();
    endtask

    task automatic run_random_traffic(input int unsigned item_count);
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        int unsigned pick;
        logic [CODE_W-1:0] code;
        int i;
        sent = 0;
        while (sent < item_count) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(COLS - 5, COLS + 10)
                                               : $urandom_range(1, 40);
                for (i = 0; i < len; i++) begin
                    code = CODE_W'($urandom_range(255));
                    if (code == NEWLINE_CODE)
                        code = 8'h20;
                    put_char(code);
                end
                sent += len;
                if ($urandom_range(99) < 60) begin
                    send_command(FN_PUT, NEWLINE_CODE, COL_FIELD_W'($urandom_range(127)),
                                 ROW_FIELD_W'($urandom_range(31)));
                    sent++;
                end
            end else if (kind < 85) begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++) begin
                    pick = $urandom_range(9);
                    if (pick < 4)
                        read_cell(COL_FIELD_W'($urandom_range(COLS - 1)),
                                  ROW_FIELD_W'(model_row));
                    else if (pick < 8)
                        read_cell(COL_FIELD_W'($urandom_range(COLS - 1)),
                                  ROW_FIELD_W'($urandom_range(ROWS - 1)));
                    else
                        read_cell(COL_FIELD_W'($urandom_range(127)),
                                  ROW_FIELD_W'($urandom_range(31)));
                end
                sent += len;
            end else if (kind < 87) begin
                clear_screen();
                sent++;
            end else if (kind < 92) begin
                send_command(FN_UNUSED, CODE_W'($urandom_range(255)),
                             COL_FIELD_W'($urandom_range(127)),
                             ROW_FIELD_W'($urandom_range(31)));
                sent++;
            end else begin
                len = $urandom_range(1, 12);
                for (i = 0; i < len; i++)
                    send_command(FN_PUT, NEWLINE_CODE, COL_FIELD_W'($urandom_range(127)),
                                 ROW_FIELD_W'($urandom_range(31)));
                sent += len;
            end
        end
    endtask

    task automatic test_random_phases();
        int unsigned src_pct [4]  = '{0, 57, 0, 20};
        int unsigned sink_pct [4] = '{0, 0, 57, 20};
        int p;
        for (p = 0; p < 4; p++) begin
            case (p)
                0: set_colors(4'hF, 4'h0);
                1: set_colors(4'h0, 4'hF);
                2: set_colors(NIBBLE_W'($urandom_range(15)), NIBBLE_W'($urandom_range(15)));
                default: set_colors(4'hF, 4'hF);
            endcase
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            run_random_traffic(180);
        end
    endtask

    initial begin
        int i;
        i_rst_n           = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.func      = FN_PUT;
        cmd_bus.char_code = '0;
        cmd_bus.cell_col  = '0;
        cmd_bus.cell_row  = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.idx       = CFG_FORE;
        cfg_bus.data      = '0;
        for (i = 0; i < ROWS * COLS; i++)
            screen_model[i] = '0;
        model_col  = 0;
        model_row  = 0;
        model_fore = FORE_RESET;
        model_back = BACK_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_commands();
        test_color_registers();
        test_wrap_and_scroll();
        test_backpressure();
        test_random_phases();

        wait_console_idle();
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_text_console_cursor_scroll: PASS");
        else
            $display("tb_text_console_cursor_scroll: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- text_console_cursor_scroll.f -----
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_if.sv
hdl/tcc_mem.sv
hdl/tcc_ctrl.sv
hdl/text_console_cursor_scroll.sv
verif/tb_text_console_cursor_scroll.sv
